FILE: hw/rtl/itad_pkg.sv
package itad_pkg;

  localparam int CMD_W = 2;
  localparam int KEY_W = 10;
  localparam int MASK_W = 32;
  localparam int WORD_W = 64;
  localparam int STATUS_W = 3;
  localparam int COUNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOD = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEL,
    OP_MOD,
    OP_BAD
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_EXISTS,
    ST_NOTFOUND,
    ST_INVALID
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] event_mask;
    logic [WORD_W-1:0] user_word;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] event_mask;
    logic [WORD_W-1:0] user_word;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hw/rtl/itad_front.sv
module itad_front
  import itad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     push_valid,
  output req_t     push_item,
  input  logic     q_full
);

  logic req_valid_r;
  req_t req_r;
  op_t  op;

  always_comb begin
    unique case (in_item.cmd)
      CMD_ADD: op = OP_ADD;
      CMD_DEL: op = OP_DEL;
      CMD_MOD: op = OP_MOD;
      default: op = OP_BAD;
    endcase
  end

  assign in_stall   = req_valid_r && q_full;
  assign push_valid = req_valid_r;
  assign push_item  = req_r;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= '{op: op, key: in_item.key, event_mask: in_item.event_mask,
                 user_word: in_item.user_word};
    end
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid_r <= 1'b1;
    end else if (!q_full) begin
      req_valid_r <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/itad_queue.sv
module itad_queue
  import itad_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  req_t    push_item,
  input  logic    pop,
  output req_t    pop_item,
  output q_stat_t stat
);

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  req_t            slot_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     fill_r;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = fill_r == (PW+1)'(QDEPTH);
  assign stat.empty = fill_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/itad_engine.sv
module itad_engine
  import itad_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  req_t      q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int SKW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [SKW-1:0]    key;
    logic [MASK_W-1:0] event_mask;
    logic [WORD_W-1:0] user_word;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_REPLY
  } state_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  state_t    state_r, state_nxt;
  req_t      req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  status_t   status_r, status_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic [IW-1:0] last_idx;
  logic          hit;
  logic          at_last;

  assign last_idx  = IW'(cnt_r - CW'(1));
  assign hit       = rd_data_r.key == req_r.key[SKW-1:0];
  assign at_last   = idx_r == last_idx;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '{key: req_r.key[SKW-1:0], event_mask: req_r.event_mask,
                      user_word: req_r.user_word};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          req_nxt = q_item;
          idx_nxt = '0;
          unique case (q_item.op)
            OP_BAD: begin
              status_nxt = ST_INVALID;
              state_nxt  = S_REPLY;
            end
            OP_ADD: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                status_nxt = ST_NOSPACE;
                state_nxt  = S_REPLY;
              end else if (cnt_r == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{key: q_item.key[SKW-1:0], event_mask: q_item.event_mask,
                               user_word: q_item.user_word};
                cnt_nxt    = cnt_r + CW'(1);
                status_nxt = ST_OK;
                state_nxt  = S_REPLY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_DEL, OP_MOD: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOTFOUND;
                state_nxt  = S_REPLY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = idx_r + 1'b1;
        if (hit) begin
          state_nxt = S_REPLY;
          case (req_r.op)
            OP_ADD: status_nxt = ST_EXISTS;
            OP_MOD: begin
              wr_en      = 1'b1;
              wr_addr    = idx_r;
              wr_data    = '{key: rd_data_r.key, event_mask: req_r.event_mask,
                             user_word: req_r.user_word};
              status_nxt = ST_OK;
            end
            OP_DEL: begin
              status_nxt = ST_OK;
              if (at_last) begin
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                rd_addr   = last_idx;
                slot_nxt  = idx_r;
                state_nxt = S_LAST;
              end
            end
            default: status_nxt = ST_INVALID;
          endcase
        end else if (at_last) begin
          state_nxt = S_REPLY;
          if (req_r.op == OP_ADD) begin
            wr_en      = 1'b1;
            wr_addr    = IW'(cnt_r);
            cnt_nxt    = cnt_r + CW'(1);
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = slot_r;
        wr_data   = rd_data_r;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: status_r, entry_count: COUNT_OUT_W'(cnt_r)};
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/interest_table_add_del_mod.sv
// interest table: add, delete and modify entries selected by key
// in_* channel takes one request item (cmd, key, event_mask, user_word);
// out_* channel returns one item per request: status and entry count after it
// both channels move an item at a clock edge with valid high and stall low
// a front register decodes the command and feeds a two-deep queue; the back
// engine scans the key store one entry per cycle through a registered read
// an empty table, a full table add or a bad command is answered without a scan;
// otherwise the scan runs until a hit or the last entry; a delete that moves
// the last entry into the freed slot writes it there from an extra state
// the engine works on one item at a time, through the single key store read port
// the front keeps taking items while the engine works until the queue fills
// a result waits in the output register while out_stall is high; the engine
// may pick up the next item meanwhile but holds its result until the slot frees
// reset empties the table (entry count zero), the queue and the output register;
// the entry store is not cleared, no clearing pass is needed
module interest_table_add_del_mod
  import itad_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic    push_valid;
  req_t    push_item;
  logic    q_pop;
  req_t    q_item;
  q_stat_t q_stat;

  itad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_stat.full)
  );

  itad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  itad_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_nospace_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_NOSPACE) |->
      out_item.entry_count == COUNT_OUT_W'(TABLE_DEPTH))
    else $error("no space reported with table not full");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (push_valid && q_stat.full))
    else $error("input stalled without a blocked front item");

endmodule
